// ----- src/fds_pkg.sv -----
// fds_pkg: shared constants and types for the frame delta smoother
// used by fds_divider, fds_window_mem and frame_delta_smoother
// no dependencies
package fds_pkg;

    // default window depth, handed to the top level as a parameter default
    localparam int DEFAULT_WINDOW_DEPTH = 16;

    // apb address width: two 32-bit registers at byte offsets 0 and 4
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register map, indexed by paddr[2]
    typedef enum logic [0:0] {
        REG_TIME_SCALE = 1'b0,
        REG_MAX_STEP   = 1'b1
    } reg_idx_t;

    // reset values: scale of 1.0 in q4.12, a third of a second in 2^-20 s
    localparam logic [15:0] TIME_SCALE_RESET = 16'd4096;
    localparam logic [31:0] MAX_STEP_RESET   = 32'd349525;

    // one second in 2^-20 s units
    localparam logic [31:0] ONE_SECOND = 32'h0010_0000;

    // scale product: 32 x 16 bits, q4.12 so drop 12 fraction bits
    localparam int SCALE_FRAC_W = 12;
    localparam int PRODUCT_W    = 48;

    // handshake status of the divider
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage : fds_pkg

// ----- src/frame_delta_smoother.sv -----
// frame_delta_smoother: frame delta smoother with step rejection, top level
// depends on fds_pkg, fds_window_mem and fds_divider
//
// usage
//   input channel: in_valid/in_ready carry one request per frame tick with
//   elapsed_raw in 2^-20 s units. output channel: out_valid/out_ready carry
//   one result per request (accepted, delta, smooth_delta, total_time,
//   smooth_total, frame_rate), held in an output register.
//   apb port: time_scale at 0x0 (q4.12), max_step at 0x4; pready always high.
// request flow
//   one request at a time; out_valid rises after the bit-serial divider
//   has formed the window mean, one bit a cycle, or after S_START and S_OUT
//   alone while the window is empty and nothing is divided; in_ready comes
//   back with out_valid, so a new request is taken only once the last result
//   stands in the output register.
//   the sample ring is read in S_MUL, written back in S_UPDATE, no forwarding
// reset and stall
//   rst_n clears all counters, sums and the fill count; the ring contents
//   are left as they are and only filled entries are ever used.
//   while out_ready is low the finished result is held and the next
//   request is still taken; its result waits in the last state until the
//   output register frees up.
module frame_delta_smoother
    import fds_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // apb configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    // request channel
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [31:0]           elapsed_raw,
    // result channel
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  accepted,
    output logic [31:0]           delta,
    output logic [31:0]           smooth_delta,
    output logic [47:0]           total_time,
    output logic [47:0]           smooth_total,
    output logic [15:0]           frame_rate
);

    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = 32 + $clog2(WINDOW_DEPTH);

    // sequencer, one-hot
    typedef enum logic [6:0] {
        S_IDLE   = 7'b000_0001,
        S_MUL    = 7'b000_0010,
        S_CHECK  = 7'b000_0100,
        S_UPDATE = 7'b000_1000,
        S_START  = 7'b001_0000,
        S_DIV    = 7'b010_0000,
        S_OUT    = 7'b100_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // configuration
    logic [15:0] time_scale_reg;
    logic [31:0] max_step_reg;
    logic        cfg_wr;

    // per-request working registers
    logic [31:0]          raw_reg;
    logic [PRODUCT_W-1:0] product_reg;
    logic [31:0]          scaled_reg;
    logic                 acc_reg;
    logic [31:0]          mean_reg;

    // block state
    logic [CNT_W-1:0] fill_count_reg;
    logic [PTR_W-1:0] write_pos_reg;
    logic [SUM_W-1:0] window_sum_reg;
    logic [31:0]      last_delta_reg;
    logic [47:0]      time_sum_reg;
    logic [47:0]      smooth_sum_reg;
    logic [15:0]      tick_count_reg;
    logic [31:0]      second_accum_reg;
    logic [15:0]      rate_latch_reg;

    // result register
    logic        out_valid_reg;
    logic        accepted_reg;
    logic [31:0] delta_reg;
    logic [31:0] smooth_delta_reg;
    logic [47:0] total_time_reg;
    logic [47:0] smooth_total_reg;
    logic [15:0] frame_rate_reg;

    // combinational helpers
    logic [31:0]      scaled;
    logic [31:0]      diff;
    logic             window_full;
    logic [SUM_W-1:0] window_sum_upd;
    logic [32:0]      sec_sum;
    logic [31:0]      sec_sat;
    logic [15:0]      tick_inc;
    logic             out_free;

    // memory and divider hookup
    logic        mem_wr_en;
    logic        mem_rd_en;
    logic [31:0] mem_rd_data;
    logic        div_start;
    logic [SUM_W-1:0] div_quotient;
    div_status_t div_stat;

    // ---------------------------------------------------------------
    // apb register file
    // ---------------------------------------------------------------
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_scale_reg <= TIME_SCALE_RESET;
            max_step_reg   <= MAX_STEP_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx_t'(paddr[2]))
                REG_TIME_SCALE: time_scale_reg <= pwdata[15:0];
                REG_MAX_STEP:   max_step_reg   <= pwdata;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[2]))
            REG_TIME_SCALE: prdata = {16'd0, time_scale_reg};
            REG_MAX_STEP:   prdata = max_step_reg;
        endcase
    end

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    assign in_ready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:    state_next = S_CHECK;
            S_CHECK:  state_next = S_UPDATE;
            S_UPDATE: state_next = S_START;
            // empty window: mean is zero, no division
            S_START:  state_next = (fill_count_reg == '0) ? S_OUT : S_DIV;
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------
    // scale and step check
    // ---------------------------------------------------------------
    // drop the q4.12 fraction, saturate anything above 32 bits
    assign scaled = (|product_reg[PRODUCT_W-1:32+SCALE_FRAC_W]) ? '1
                  : product_reg[31+SCALE_FRAC_W:SCALE_FRAC_W];
    assign diff   = (scaled >= last_delta_reg) ? (scaled - last_delta_reg)
                  : (last_delta_reg - scaled);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            raw_reg <= elapsed_raw;
        end
        if (state_reg == S_MUL)
        begin
            product_reg <= raw_reg * {16'd0, time_scale_reg};
        end
        if (state_reg == S_CHECK)
        begin
            scaled_reg <= scaled;
            acc_reg    <= (diff < max_step_reg);
        end
    end

    // ---------------------------------------------------------------
    // window ring: read the slot about to be overwritten, write it back
    // ---------------------------------------------------------------
    assign mem_rd_en = (state_reg == S_MUL);
    assign mem_wr_en = (state_reg == S_UPDATE) && acc_reg;

    fds_window_mem #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .PTR_W        (PTR_W)
    ) u_window_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (write_pos_reg),
        .wr_data (scaled_reg),
        .rd_en   (mem_rd_en),
        .rd_addr (write_pos_reg),
        .rd_data (mem_rd_data)
    );

    // full window: oldest sample leaves as the new one enters
    assign window_full    = (fill_count_reg == CNT_W'(WINDOW_DEPTH));
    assign window_sum_upd = window_sum_reg
                          - (window_full ? SUM_W'(mem_rd_data) : '0)
                          + SUM_W'(scaled_reg);

    // per-second frame counter
    assign sec_sum  = {1'b0, second_accum_reg} + {1'b0, scaled_reg};
    assign sec_sat  = sec_sum[32] ? '1 : sec_sum[31:0];
    assign tick_inc = (tick_count_reg != 16'hFFFF) ? (tick_count_reg + 16'd1)
                    : tick_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_count_reg   <= '0;
            write_pos_reg    <= '0;
            window_sum_reg   <= '0;
            last_delta_reg   <= '0;
            time_sum_reg     <= '0;
            smooth_sum_reg   <= '0;
            tick_count_reg   <= '0;
            second_accum_reg <= '0;
            rate_latch_reg   <= '0;
        end
        else
        begin
            if (state_reg == S_UPDATE)
            begin
                if (acc_reg)
                begin
                    if (!window_full)
                    begin
                        fill_count_reg <= fill_count_reg + 1'b1;
                    end
                    window_sum_reg <= window_sum_upd;
                    write_pos_reg  <= (write_pos_reg == PTR_W'(WINDOW_DEPTH - 1)) ? '0
                                    : write_pos_reg + 1'b1;
                    last_delta_reg <= scaled_reg;
                    time_sum_reg   <= time_sum_reg + {16'd0, scaled_reg};
                end
                // every tick counts, accepted or not
                if (sec_sat > ONE_SECOND)
                begin
                    rate_latch_reg   <= tick_inc;
                    tick_count_reg   <= '0;
                    second_accum_reg <= '0;
                end
                else
                begin
                    tick_count_reg   <= tick_inc;
                    second_accum_reg <= sec_sat;
                end
            end
            if (state_reg == S_DIV && div_stat.done && acc_reg)
            begin
                smooth_sum_reg <= smooth_sum_reg + {16'd0, div_quotient[31:0]};
            end
        end
    end

    // ---------------------------------------------------------------
    // window mean
    // ---------------------------------------------------------------
    assign div_start = (state_reg == S_START) && (fill_count_reg != '0);

    fds_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (window_sum_reg),
        .divisor  (fill_count_reg),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    // mean never exceeds the largest sample, so 32 bits hold it
    always_ff @(posedge clk)
    begin
        if (state_reg == S_START)
        begin
            mean_reg <= '0;
        end
        else if (state_reg == S_DIV && div_stat.done)
        begin
            mean_reg <= div_quotient[31:0];
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_OUT && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && out_free)
        begin
            accepted_reg     <= acc_reg;
            delta_reg        <= last_delta_reg;
            smooth_delta_reg <= mean_reg;
            total_time_reg   <= time_sum_reg;
            smooth_total_reg <= smooth_sum_reg;
            frame_rate_reg   <= rate_latch_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign accepted     = accepted_reg;
    assign delta        = delta_reg;
    assign smooth_delta = smooth_delta_reg;
    assign total_time   = total_time_reg;
    assign smooth_total = smooth_total_reg;
    assign frame_rate   = frame_rate_reg;

`ifndef SYNTHESIS
    // fill count never runs past the window
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_count_reg <= CNT_W'(WINDOW_DEPTH))
        else $error("fill count beyond window depth");

    // divider only finishes while the sequencer waits for it
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_DIV))
        else $error("divider done outside wait state");

    // a result only appears from the final state
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    // a rejected sample leaves the window untouched
    a_reject_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE && !acc_reg) |=>
            ($stable(fill_count_reg) && $stable(window_sum_reg)))
        else $error("rejected sample changed the window");
`endif

endmodule : frame_delta_smoother

// ----- src/fds_divider.sv -----
// fds_divider: restoring divider, one quotient bit per cycle
// computes the window mean; depends on fds_pkg
module fds_divider
    import fds_pkg::*;
#(
    parameter int DIVIDEND_W = 32 + $clog2(DEFAULT_WINDOW_DEPTH),
    parameter int DIVISOR_W  = $clog2(DEFAULT_WINDOW_DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic [DIVIDEND_W-1:0] quotient,
    output div_status_t           status
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  divisor_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [DIVISOR_W:0]    rem_shift;
    logic [DIVISOR_W:0]    rem_diff;
    logic                  q_bit;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
        rem_diff  = rem_shift - {1'b0, divisor_reg};
        q_bit     = (rem_shift >= {1'b0, divisor_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(DIVIDEND_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, no reset needed
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= '0;
            quo_reg     <= dividend;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= q_bit ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], q_bit};
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule : fds_divider

// ----- src/fds_window_mem.sv -----
// fds_window_mem: sample ring storage, one write and one read port
// read data registered; depends on fds_pkg
module fds_window_mem
    import fds_pkg::*;
#(
    parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH,
    parameter int PTR_W        = (DEFAULT_WINDOW_DEPTH > 1) ? $clog2(DEFAULT_WINDOW_DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [PTR_W-1:0] wr_addr,
    input  logic [31:0]      wr_data,
    input  logic             rd_en,
    input  logic [PTR_W-1:0] rd_addr,
    output logic [31:0]      rd_data
);

    logic [31:0] mem [WINDOW_DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule : fds_window_mem

// ----- sim/frame_delta_smoother_tb.sv -----
// frame_delta_smoother_tb: self-checking testbench for the frame delta smoother
// drives frame ticks and apb register writes, predicts every result and compares
// depends on fds_pkg and the frame_delta_smoother rtl
module frame_delta_smoother_tb;
    import fds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN = DEFAULT_WINDOW_DEPTH;
    // idle time after a drain before anything else touches the block
    localparam int SETTLE_CYCLES = 80;
    // watchdog limit in ns, many times the slowest legal run
    localparam int WATCHDOG_NS = 8_000_000;
    localparam int RANDOM_PHASES = 7;
    localparam int FRAMES_PER_PHASE = 150;

    // one expected result per frame tick
    typedef struct {
        bit        accepted;
        bit [31:0] delta;
        bit [31:0] smooth_delta;
        bit [47:0] total_time;
        bit [47:0] smooth_total;
        bit [15:0] frame_rate;
    } tick_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [31:0]           elapsed_raw = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  accepted;
    logic [31:0]           delta;
    logic [31:0]           smooth_delta;
    logic [47:0]           total_time;
    logic [47:0]           smooth_total;
    logic [15:0]           frame_rate;

    frame_delta_smoother u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .elapsed_raw  (elapsed_raw),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .accepted     (accepted),
        .delta        (delta),
        .smooth_delta (smooth_delta),
        .total_time   (total_time),
        .smooth_total (smooth_total),
        .frame_rate   (frame_rate)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // shadow copy of the smoother: registers and state as they stand
    // after reset
    // ------------------------------------------------------------------
    bit [15:0]   scale_q    = TIME_SCALE_RESET;
    bit [31:0]   step_limit = MAX_STEP_RESET;
    bit [31:0]   ring [WIN];
    int unsigned ring_fill  = 0;
    int unsigned ring_pos   = 0;
    bit [35:0]   ring_sum   = '0;
    bit [31:0]   prev_delta = '0;
    bit [47:0]   time_acc   = '0;
    bit [47:0]   smooth_acc = '0;
    bit [15:0]   tick_cnt   = '0;
    bit [31:0]   sec_accum  = '0;
    bit [15:0]   rate_hold  = '0;

    // frame ticks waiting to be sent, and the results owed by the block
    bit [31:0]    raw_backlog[$];
    tick_result_t expected_ticks[$];

    int  fail_count = 0;
    bit  in_busy    = 1'b0;   // a request is on the bus and not yet taken
    bit  no_idle    = 1'b0;   // closing stretch runs flat out
    int  src_gap    = 0;
    int  src_calm   = 0;
    int  snk_stall  = 0;
    int  snk_calm   = 0;
    bit [31:0] nominal_raw = 32'd17476;  // about 1/60 s

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
    endtask

    // truncated window mean, zero while nothing has been accepted
    function automatic bit [31:0] window_mean();
        if (ring_fill == 0)
            return '0;
        return 32'(ring_sum / ring_fill);
    endfunction

    // one frame tick through the shadow state; queues the result it owes
    function automatic void advance_smoother(input bit [31:0] raw);
        bit [47:0]    product;
        bit [35:0]    shifted;
        bit [31:0]    scaled;
        bit [31:0]    step_gap;
        bit [32:0]    accum_next;
        bit           taken;
        tick_result_t r;

        // q4.12 scale, drop the fraction, clamp at 32 bits
        product = {16'd0, raw} * {32'd0, scale_q};
        shifted = product[47:12];
        scaled  = (shifted[35:32] != 4'd0) ? 32'hFFFF_FFFF : shifted[31:0];

        step_gap = (scaled >= prev_delta) ? scaled - prev_delta : prev_delta - scaled;
        taken    = step_gap < step_limit;

        if (taken)
        begin
            // a full ring drops its oldest sample as the new one lands
            if (ring_fill >= WIN)
                ring_sum -= ring[ring_pos];
            else
                ring_fill++;
            ring[ring_pos] = scaled;
            ring_sum      += scaled;
            ring_pos       = (ring_pos + 1) % WIN;
            prev_delta     = scaled;
            time_acc      += scaled;
            smooth_acc    += window_mean();
        end

        // rejected ticks still count as frames and still add time
        if (tick_cnt != 16'hFFFF)
            tick_cnt++;
        accum_next = {1'b0, sec_accum} + {1'b0, scaled};
        sec_accum  = accum_next[32] ? 32'hFFFF_FFFF : accum_next[31:0];
        if (sec_accum > ONE_SECOND)
        begin
            rate_hold = tick_cnt;
            tick_cnt  = '0;
            sec_accum = '0;
        end

        r.accepted     = taken;
        r.delta        = prev_delta;
        r.smooth_delta = window_mean();
        r.total_time   = time_acc;
        r.smooth_total = smooth_acc;
        r.frame_rate   = rate_hold;
        expected_ticks.push_back(r);
    endfunction

    // mostly steady frame times with jitter, some new rates, spikes and noise
    function automatic bit [31:0] next_frame();
        bit [31:0] jitter;
        int        pick;

        pick = $urandom_range(0, 19);
        if (pick <= 13)
        begin
            jitter = $urandom_range(0, nominal_raw / 8);
            return ($urandom_range(0, 1) == 1) ? nominal_raw + jitter
                                               : nominal_raw - jitter;
        end
        if (pick <= 15)
        begin
            nominal_raw = $urandom_range(500, 400000);
            return nominal_raw;
        end
        if (pick <= 17)
            return nominal_raw * $urandom_range(3, 20);
        if (pick == 18)
            return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'd0;
        return $urandom;
    endfunction

    // an idle burst now and then, none in calm stretches or the closing stretch
    function automatic int idle_burst(input int odds, input int calm);
        if (no_idle || calm != 0)
            return 0;
        if ($urandom_range(1, odds) == 1)
            return $urandom_range(1, 14);
        return 0;
    endfunction

    // ------------------------------------------------------------------
    // driver: presents requests and toggles out_ready on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            // request side: an offered request holds until it is taken
            if (!in_busy)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    in_valid <= 1'b0;
                end
                else if (raw_backlog.size() != 0)
                begin
                    elapsed_raw <= raw_backlog.pop_front();
                    in_valid    <= 1'b1;
                    in_busy      = 1'b1;
                    if (src_calm > 0)
                        src_calm--;
                    else if ($urandom_range(0, 29) == 0)
                        src_calm = $urandom_range(10, 40);
                    src_gap = idle_burst(4, src_calm);
                end
                else
                    in_valid <= 1'b0;
            end

            // result side: random stalls with quiet stretches between them
            if (snk_calm > 0)
                snk_calm--;
            else if ($urandom_range(0, 199) == 0)
                snk_calm = $urandom_range(50, 300);
            if (snk_stall == 0)
                snk_stall = idle_burst(20, snk_calm);
            if (snk_stall > 0)
            begin
                snk_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: predicts on each taken request, checks each delivered result
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        tick_result_t want;

        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                advance_smoother(elapsed_raw);
                in_busy = 1'b0;
            end
            if (out_valid && out_ready)
            begin
                if (expected_ticks.size() == 0)
                    flag_mismatch("result with no request outstanding");
                else
                begin
                    want = expected_ticks.pop_front();
                    check_field("accepted",     accepted,     want.accepted);
                    check_field("delta",        delta,        want.delta);
                    check_field("smooth_delta", smooth_delta, want.smooth_delta);
                    check_field("total_time",   total_time,   want.total_time);
                    check_field("smooth_total", smooth_total, want.smooth_total);
                    check_field("frame_rate",   frame_rate,   want.frame_rate);
                end
            end
        end
    end

    // sender holds off until every owed result is back, then lets the
    // block settle before anything else touches it
    task automatic drain();
        while (raw_backlog.size() != 0 || in_busy || expected_ticks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // apb write (setup then access), shadow update, then a read-back check
    task automatic set_register(input reg_idx_t idx, input bit [31:0] value);
        logic [31:0] got;
        bit   [31:0] want;

        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;

        if (idx == REG_TIME_SCALE)
        begin
            scale_q = value[15:0];
            want    = {16'd0, value[15:0]};
        end
        else
        begin
            step_limit = value;
            want       = value;
        end

        psel  = 1'b1;
        paddr = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        got = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        check_field(idx == REG_TIME_SCALE ? "time_scale read-back" : "max_step read-back",
                    got, want);
    endtask

    task automatic apply_setting(input bit [15:0] scale, input bit [31:0] step);
        set_register(REG_TIME_SCALE, {16'd0, scale});
        set_register(REG_MAX_STEP, step);
    endtask

    // ------------------------------------------------------------------
    // stimulus: directed ticks under fixed settings, then random phases
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        bit [15:0] scale;
        bit [31:0] step;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: steady frames, a big jump that is rejected,
        // a small one, exactly one second of raw time
        raw_backlog.push_back(32'd0);
        raw_backlog.push_back(32'd17476);
        raw_backlog.push_back(32'd17476);
        raw_backlog.push_back(32'd317476);
        raw_backlog.push_back(32'd1000000);
        raw_backlog.push_back(32'd16667);
        raw_backlog.push_back(32'h0010_0000);
        raw_backlog.push_back(32'd349525);
        drain();

        // largest scale and step: scale overflow clamps, the second
        // accumulator saturates, and a full-range step is still rejected
        apply_setting(16'hFFFF, 32'hFFFF_FFFF);
        raw_backlog.push_back(32'hFFFF_FFFF);
        raw_backlog.push_back(32'd5);
        raw_backlog.push_back(32'hFFFF_FFFF);
        raw_backlog.push_back(32'd0);
        raw_backlog.push_back(32'd1);
        raw_backlog.push_back(32'h8000_0000);
        drain();

        // zero scale and zero step: nothing can ever be accepted
        apply_setting(16'd0, 32'd0);
        raw_backlog.push_back(32'hFFFF_FFFF);
        raw_backlog.push_back(32'd12345);
        raw_backlog.push_back(32'd0);
        drain();

        // tiniest scale, unit step: only a repeat of the last delta passes
        apply_setting(16'd1, 32'd1);
        raw_backlog.push_back(32'd4096);
        raw_backlog.push_back(32'd8191);
        raw_backlog.push_back(32'hFFFF_FFFF);
        raw_backlog.push_back(32'd8192);
        drain();

        // random phases, the last one at reset settings with no idling
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            if (p == RANDOM_PHASES - 1)
            begin
                scale   = TIME_SCALE_RESET;
                step    = MAX_STEP_RESET;
                no_idle = 1'b1;
            end
            else
            begin
                case ($urandom_range(0, 4))
                    0:       scale = TIME_SCALE_RESET;
                    1:       scale = 16'($urandom_range(2048, 8192));
                    2:       scale = 16'($urandom_range(0, 65535));
                    3:       scale = 16'hFFFF;
                    default: scale = 16'($urandom_range(1, 512));
                endcase
                case ($urandom_range(0, 4))
                    0:       step = MAX_STEP_RESET;
                    1:       step = $urandom;
                    2:       step = 32'hFFFF_FFFF;
                    3:       step = $urandom_range(1000, 100000);
                    default: step = (p == 0) ? 32'd0 : $urandom_range(100, 400000);
                endcase
            end
            apply_setting(scale, step);
            for (int i = 0; i < FRAMES_PER_PHASE; i++)
                raw_backlog.push_back(next_frame());
            drain();
        end

        if (fail_count == 0)
            $display("frame_delta_smoother verification clean");
        else
            $display("frame_delta_smoother verification failed");
        $finish;
    end

    // hard stop should the block hang
    initial
    begin
        #WATCHDOG_NS;
        $display("frame_delta_smoother verification failed");
        $finish;
    end

endmodule : frame_delta_smoother_tb
